// ===== design/csld_pkg.sv =====
// shared types and constants of the cell stream line decoder
package csld_pkg;

   // decoder sequencing states
   typedef enum logic [1:0] {
      DEC_IDLE,
      DEC_ACTIVE,
      DEC_RUN
   } dec_state_type;

   // one frame store entry
   typedef struct packed {
      logic [15:0] mask;
      logic [7:0]  color0;
      logic [7:0]  color1;
   } cell_type;

   // one update report
   typedef struct packed {
      logic [6:0]  cell_row;
      logic [7:0]  cell_col;
      logic [8:0]  cell_count;
      logic        mask_written;
      logic        color0_written;
      logic        color1_written;
      logic [15:0] mask_value;
      logic [7:0]  color0_value;
      logic [7:0]  color1_value;
      logic [1:0]  status;
      logic        row_done;
      logic        frame_done;
   } report_type;

   // report status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_OVERRUN    = 2'd1;
   localparam logic [1:0] STATUS_BAD_ESCAPE = 2'd2;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_FRAME_COLS    = 2'd0;
   localparam logic [1:0] CSR_FRAME_ROWS    = 2'd1;
   localparam logic [1:0] CSR_LINES_TO_BURN = 2'd2;

   // opcode fields of the first byte of a code
   localparam logic [7:0] LITERAL_FLAG = 8'h80;
   localparam logic [7:0] ESCAPE_FLAG  = 8'h40;
   localparam logic [7:0] SKIP_MASK    = 8'h3F;

   // register values after reset
   localparam logic [8:0] FRAME_COLS_RESET    = 9'd160;
   localparam logic [7:0] FRAME_ROWS_RESET    = 8'd120;
   localparam logic [7:0] LINES_TO_BURN_RESET = 8'd0;

endpackage

// ===== design/cell_stream_line_decoder_core.sv =====
// top level of the cell stream line decoder
//
// Bytes of a 4x4-cell video stream enter on the req_ channel (valid/stall) and
// are decoded into a frame store of MAX_ROWS x MAX_COLS cells, starting at row
// frame_rows - lines_to_burn. Every finished code gives one update report on
// the rsp_ channel (valid/stall). Registers are written on the csr_ channel
// (valid/ready, always ready); a write to index 0, 1 or 2 restarts decoding.
// Throughput: one byte per cycle while req_stall is low. A solid run holds
// the input until all its cells are written, one frame store write per cell.
// The cycle after a register write the input is held while the start row
// is set up. A report is pushed into the report queue when the last byte
// of its code is transferred, and shown on the rsp_ ports once the reports
// ahead of it are taken. Escapes read the current cell at the first byte of
// the code and, unless unknown, write the updated entry back at its last byte.
// Reset: the MAX_ROWS * MAX_COLS frame store entries (32768 with the
// defaults) are zero filled while the input is held; csr writes are taken.
// When the receiver stalls, one more report is held in a second slot; the
// input is held only once both slots are full.
module cell_stream_line_decoder_core #(
   parameter int MAX_COLS         = 256,
   parameter int MAX_ROWS         = 128,
   parameter int COLORS_ONLY_CODE = 252,
   parameter int COLOR0_ONLY_CODE = 253,
   parameter int COLOR1_ONLY_CODE = 254,
   parameter int MASK_ONLY_CODE   = 255
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   // update reports
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cell_row,
   output logic [7:0]  rsp_cell_col,
   output logic [8:0]  rsp_cell_count,
   output logic        rsp_mask_written,
   output logic        rsp_color0_written,
   output logic        rsp_color1_written,
   output logic [15:0] rsp_mask_value,
   output logic [7:0]  rsp_color0_value,
   output logic [7:0]  rsp_color1_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_row_done,
   output logic        rsp_frame_done,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import csld_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W  = (COL_W > 9) ? COL_W : 9;

   // configuration registers
   logic [8:0]        frame_cols_ff, frame_cols_in;
   logic [7:0]        frame_rows_ff, frame_rows_in;
   logic [7:0]        lines_to_burn_ff, lines_to_burn_in;
   logic              restart_ff, restart_in;

   // decoder state
   dec_state_type     state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        byte0_ff, byte0_in;
   logic [7:0]        byte1_ff, byte1_in;
   logic [7:0]        byte2_ff, byte2_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;

   // run write sequencer
   logic [ADDR_W-1:0] run_addr_ff, run_addr_in;
   logic [LEN_W-1:0]  run_left_ff, run_left_in;
   cell_type          run_entry_ff, run_entry_in;
   logic              run_stop_ff, run_stop_in;

   logic [COL_W-1:0]  eff_cols;
   logic [ROW_W-1:0]  eff_rows;
   logic [ROW_W-1:0]  burn;
   logic [ROW_W-1:0]  start_row;
   logic              start_active;

   logic              csr_fire;
   logic              byte_fire;
   logic              dec_fire;
   logic              code_fire;
   logic              decode_on;
   logic              run_busy;
   logic              clear_busy;
   logic              queue_full;

   logic [7:0]        k0, k1, k2, k3;
   logic [2:0]        code_len;
   logic              code_last;
   logic [ADDR_W-1:0] cur_addr;

   report_type        rep;
   report_type        rsp_data;
   logic [LEN_W-1:0]  avail;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  sum_col;
   logic [ROW_W-1:0]  row_next;
   logic [COL_W-1:0]  col_next;
   logic [ROW_W-1:0]  row_upd;
   logic              stop;
   logic              advance;
   logic              is_run;
   logic              run_more;
   logic              cell_wr;
   cell_type          cell_data;
   cell_type          entry;

   logic              store_wr_en;
   logic [ADDR_W-1:0] store_wr_addr;
   cell_type          store_wr_data;
   logic              store_rd_en;
   cell_type          store_rd_data;

   // effective frame geometry
   always_comb begin
      if (frame_cols_ff == '0) begin
         eff_cols = COL_W'(1);
      end else if (32'(frame_cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = COL_W'(MAX_COLS);
      end else begin
         eff_cols = COL_W'(frame_cols_ff);
      end
      if (frame_rows_ff == '0) begin
         eff_rows = ROW_W'(1);
      end else if (32'(frame_rows_ff) > 32'(MAX_ROWS)) begin
         eff_rows = ROW_W'(MAX_ROWS);
      end else begin
         eff_rows = ROW_W'(frame_rows_ff);
      end
      if (32'(lines_to_burn_ff) > 32'(eff_rows)) begin
         burn = eff_rows;
      end else begin
         burn = ROW_W'(lines_to_burn_ff);
      end
      start_row    = eff_rows - burn;
      start_active = (burn != '0);
   end

   // register writes
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      frame_cols_in    = frame_cols_ff;
      frame_rows_in    = frame_rows_ff;
      lines_to_burn_in = lines_to_burn_ff;
      restart_in       = 1'b0;
      if (csr_fire) begin
         restart_in = csr_index inside {CSR_FRAME_COLS, CSR_FRAME_ROWS, CSR_LINES_TO_BURN};
         case (csr_index)
            CSR_FRAME_COLS:    frame_cols_in    = csr_wdata;
            CSR_FRAME_ROWS:    frame_rows_in    = csr_wdata[7:0];
            CSR_LINES_TO_BURN: lines_to_burn_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff    <= FRAME_COLS_RESET;
         frame_rows_ff    <= FRAME_ROWS_RESET;
         lines_to_burn_ff <= LINES_TO_BURN_RESET;
         restart_ff       <= 1'b0;
      end else begin
         frame_cols_ff    <= frame_cols_in;
         frame_rows_ff    <= frame_rows_in;
         lines_to_burn_ff <= lines_to_burn_in;
         restart_ff       <= restart_in;
      end
   end

   // byte transfer and code assembly
   assign req_stall = clear_busy || run_busy || restart_ff || queue_full;
   assign byte_fire = req_valid && !req_stall;
   assign dec_fire  = byte_fire && decode_on;

   assign k0 = (phase_ff == 2'd0) ? req_stream_byte : byte0_ff;
   assign k1 = (phase_ff == 2'd1) ? req_stream_byte : byte1_ff;
   assign k2 = (phase_ff == 2'd2) ? req_stream_byte : byte2_ff;
   assign k3 = req_stream_byte;

   // code length from the first byte
   always_comb begin
      if ((k0 & LITERAL_FLAG) == 8'h00) begin
         code_len = 3'd4;
      end else if ((k0 & ESCAPE_FLAG) == 8'h00) begin
         code_len = 3'd1;
      end else if (k0 == 8'(COLORS_ONLY_CODE)) begin
         code_len = 3'd3;
      end else if (k0 == 8'(COLOR0_ONLY_CODE)) begin
         code_len = 3'd2;
      end else if (k0 == 8'(COLOR1_ONLY_CODE)) begin
         code_len = 3'd2;
      end else if (k0 == 8'(MASK_ONLY_CODE)) begin
         code_len = 3'd3;
      end else begin
         code_len = 3'd1;
      end
   end

   assign code_last = (3'(phase_ff) + 3'd1) == code_len;
   assign code_fire = dec_fire && code_last;
   assign cur_addr  = ADDR_W'(32'(row_ff) * 32'(MAX_COLS) + 32'(col_ff));

   // decode of a finished code
   always_comb begin
      rep          = '0;
      rep.cell_row = 7'(row_ff);
      rep.cell_col = 8'(col_ff);
      rep.status   = STATUS_OK;
      len          = '0;
      stop         = 1'b0;
      advance      = 1'b1;
      is_run       = 1'b0;
      cell_wr      = 1'b0;
      cell_data    = '0;
      entry        = store_rd_data;
      avail        = LEN_W'(eff_cols) - LEN_W'(col_ff);
      if ((k0 & LITERAL_FLAG) == 8'h00) begin
         rep.mask_written   = 1'b1;
         rep.color0_written = 1'b1;
         rep.color1_written = 1'b1;
         cell_wr            = 1'b1;
         if ({k0, k1} != 16'h0000) begin
            // single cell with its own mask
            len              = LEN_W'(1);
            cell_data.mask   = {k0, k1};
            cell_data.color0 = k3;
            cell_data.color1 = k2;
            rep.mask_value   = {k0, k1};
            rep.color0_value = k3;
            rep.color1_value = k2;
         end else begin
            // solid run, clipped at the row end
            is_run = 1'b1;
            len    = LEN_W'(k3) + LEN_W'(1);
            if (len > avail) begin
               len        = avail;
               rep.status = STATUS_OVERRUN;
               stop       = 1'b1;
            end
            cell_data.color0 = k2;
            cell_data.color1 = k2;
            rep.color0_value = k2;
            rep.color1_value = k2;
         end
      end else if ((k0 & ESCAPE_FLAG) == 8'h00) begin
         // skip, clipped at the row end
         len = LEN_W'(k0 & SKIP_MASK) + LEN_W'(1);
         if (len > avail) begin
            len        = avail;
            rep.status = STATUS_OVERRUN;
            stop       = 1'b1;
         end
      end else begin
         // escape: patch the entry read at the first byte
         len = LEN_W'(1);
         if (k0 == 8'(COLORS_ONLY_CODE)) begin
            entry.color0       = k1;
            entry.color1       = k2;
            rep.color0_written = 1'b1;
            rep.color1_written = 1'b1;
            rep.color0_value   = k1;
            rep.color1_value   = k2;
         end else if (k0 == 8'(COLOR0_ONLY_CODE)) begin
            entry.color0       = k1;
            rep.color0_written = 1'b1;
            rep.color0_value   = k1;
         end else if (k0 == 8'(COLOR1_ONLY_CODE)) begin
            entry.color1       = k1;
            rep.color1_written = 1'b1;
            rep.color1_value   = k1;
         end else if (k0 == 8'(MASK_ONLY_CODE)) begin
            entry.mask       = {k1, k2};
            rep.mask_written = 1'b1;
            rep.mask_value   = {k1, k2};
         end else begin
            len        = '0;
            rep.status = STATUS_BAD_ESCAPE;
            stop       = 1'b1;
            advance    = 1'b0;
         end
         cell_wr   = advance;
         cell_data = entry;
      end
      rep.cell_count = 9'(len);

      // position update and row / frame end
      sum_col  = LEN_W'(col_ff) + len;
      row_next = row_ff + 1'b1;
      col_next = COL_W'(sum_col);
      row_upd  = row_ff;
      if (advance && (sum_col >= LEN_W'(eff_cols))) begin
         rep.row_done = 1'b1;
         col_next     = '0;
         row_upd      = row_next;
         if (row_next >= eff_rows) begin
            rep.frame_done = 1'b1;
            stop           = 1'b1;
         end
      end
      run_more = is_run && (len > LEN_W'(1));
   end

   // next state of the decoder
   always_comb begin
      state_in = state_ff;
      if (restart_ff) begin
         state_in = start_active ? DEC_ACTIVE : DEC_IDLE;
      end else begin
         case (state_ff)
            DEC_ACTIVE: begin
               if (code_fire) begin
                  if (run_more) begin
                     state_in = DEC_RUN;
                  end else if (stop) begin
                     state_in = DEC_IDLE;
                  end
               end
            end
            DEC_RUN: begin
               if (run_left_ff == LEN_W'(1)) begin
                  state_in = run_stop_ff ? DEC_IDLE : DEC_ACTIVE;
               end
            end
            DEC_IDLE: ;
            default: state_in = DEC_IDLE;
         endcase
      end
   end

   // decoder state outputs
   always_comb begin
      decode_on = (state_ff == DEC_ACTIVE);
      run_busy  = (state_ff == DEC_RUN);
   end

   // code bytes, position and run sequencer
   always_comb begin
      phase_in     = phase_ff;
      byte0_in     = byte0_ff;
      byte1_in     = byte1_ff;
      byte2_in     = byte2_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      run_addr_in  = run_addr_ff;
      run_left_in  = run_left_ff;
      run_entry_in = run_entry_ff;
      run_stop_in  = run_stop_ff;
      if (restart_ff) begin
         phase_in = '0;
         row_in   = start_row;
         col_in   = '0;
      end else if (dec_fire) begin
         phase_in = code_last ? 2'd0 : phase_ff + 2'd1;
         case (phase_ff)
            2'd0:    byte0_in = req_stream_byte;
            2'd1:    byte1_in = req_stream_byte;
            2'd2:    byte2_in = req_stream_byte;
            default: ;
         endcase
         if (code_last) begin
            row_in       = row_upd;
            col_in       = col_next;
            run_addr_in  = cur_addr + 1'b1;
            run_left_in  = len - LEN_W'(1);
            run_entry_in = cell_data;
            run_stop_in  = stop;
         end
      end else if (run_busy) begin
         run_addr_in = run_addr_ff + 1'b1;
         run_left_in = run_left_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= DEC_IDLE;
         phase_ff    <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         run_left_ff <= '0;
         run_stop_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         run_left_ff <= run_left_in;
         run_stop_ff <= run_stop_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff     <= byte0_in;
      byte1_ff     <= byte1_in;
      byte2_ff     <= byte2_in;
      run_addr_ff  <= run_addr_in;
      run_entry_ff <= run_entry_in;
   end

   // frame store access: read the current cell at a code start, write at its end
   // (until a restart, the next code always targets a cell past the last one written)
   assign store_rd_en   = dec_fire && (phase_ff == 2'd0);
   assign store_wr_en   = run_busy || (code_fire && cell_wr);
   assign store_wr_addr = run_busy ? run_addr_ff : cur_addr;
   assign store_wr_data = run_busy ? run_entry_ff : cell_data;

   csld_frame_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (store_wr_en),
      .wr_addr    (store_wr_addr),
      .wr_data    (store_wr_data),
      .rd_en      (store_rd_en),
      .rd_addr    (cur_addr),
      .rd_data    (store_rd_data),
      .clear_busy (clear_busy)
   );

   // report queue
   csld_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (code_fire),
      .push_data (rep),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (queue_full)
   );

   assign rsp_cell_row       = rsp_data.cell_row;
   assign rsp_cell_col       = rsp_data.cell_col;
   assign rsp_cell_count     = rsp_data.cell_count;
   assign rsp_mask_written   = rsp_data.mask_written;
   assign rsp_color0_written = rsp_data.color0_written;
   assign rsp_color1_written = rsp_data.color1_written;
   assign rsp_mask_value     = rsp_data.mask_value;
   assign rsp_color0_value   = rsp_data.color0_value;
   assign rsp_color1_value   = rsp_data.color1_value;
   assign rsp_status         = rsp_data.status;
   assign rsp_row_done       = rsp_data.row_done;
   assign rsp_frame_done     = rsp_data.frame_done;

   // a run never starts while the store is still being cleared
   assert property (@(posedge clock) disable iff (reset) run_busy |-> !clear_busy)
      else $error("run write during frame store clear");

   // a report is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) code_fire |-> !queue_full)
      else $error("report pushed into full queue");

   // an unknown escape leaves the decoder idle
   assert property (@(posedge clock) disable iff (reset)
      (code_fire && (rep.status == STATUS_BAD_ESCAPE)) |=> (state_ff == DEC_IDLE))
      else $error("decoder still active after unknown escape");

   // the run sequencer always has a cell left to write
   assert property (@(posedge clock) disable iff (reset) run_busy |-> (run_left_ff != '0))
      else $error("run sequencer active with no cells left");

endmodule

// ===== design/csld_frame_store.sv =====
// frame store memory with a zero fill sweep after reset
module csld_frame_store #(
   parameter  int DEPTH  = 32768,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  csld_pkg::cell_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output csld_pkg::cell_type  rd_data,
   output logic                clear_busy
);
   import csld_pkg::*;

   cell_type            mem [DEPTH];
   cell_type            rd_data_ff;
   logic                clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]   clear_addr_ff, clear_addr_in;
   logic                port_en;
   logic [ADDR_W-1:0]   port_addr;
   cell_type            port_data;

   // sweep one entry per cycle until the last one is cleared
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // write port shared between the sweep and the decoder
   always_comb begin
      port_en   = wr_en;
      port_addr = wr_addr;
      port_data = wr_data;
      if (clear_busy_ff) begin
         port_en   = 1'b1;
         port_addr = clear_addr_ff;
         port_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (port_en) begin
         mem[port_addr] <= port_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// ===== design/csld_out_queue.sv =====
// two-entry report queue between the decoder and the result channel
module csld_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csld_pkg::report_type  push_data,
   input  logic                  out_stall,
   output logic                  out_valid,
   output csld_pkg::report_type  out_data,
   output logic                  full
);
   import csld_pkg::*;

   logic       head_valid_ff, head_valid_in;
   logic       tail_valid_ff, tail_valid_in;
   report_type head_ff, head_in;
   report_type tail_ff, tail_in;

   // head moves on when empty or taken, tail catches a push behind a stalled head
   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (!head_valid_ff || !out_stall) begin
         if (tail_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = tail_ff;
            tail_valid_in = push;
            tail_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         tail_valid_in = 1'b1;
         tail_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign full      = tail_valid_ff;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the cell stream line decoder
`timescale 1ns / 100ps

module tb_top;
   import csld_pkg::*;

   localparam int MAX_COLS     = 256;
   localparam int MAX_ROWS     = 128;
   localparam int STORE_CELLS  = MAX_COLS * MAX_ROWS;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_TIME  = MAX_COLS + 8;

   // escape opcodes of the decoder instance
   localparam logic [7:0] OP_COLORS_ONLY = 8'd252;
   localparam logic [7:0] OP_COLOR0_ONLY = 8'd253;
   localparam logic [7:0] OP_COLOR1_ONLY = 8'd254;
   localparam logic [7:0] OP_MASK_ONLY   = 8'd255;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_cell_row;
   logic [7:0]  rsp_cell_col;
   logic [8:0]  rsp_cell_count;
   logic        rsp_mask_written;
   logic        rsp_color0_written;
   logic        rsp_color1_written;
   logic [15:0] rsp_mask_value;
   logic [7:0]  rsp_color0_value;
   logic [7:0]  rsp_color1_value;
   logic [1:0]  rsp_status;
   logic        rsp_row_done;
   logic        rsp_frame_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_FRAME_COLS;
   logic [8:0]  csr_wdata = 9'd0;

   // stimulus bytes waiting for the driver, reports waiting for the decoder
   logic [7:0] byte_queue [$];
   report_type expected_reports [$];
   int unsigned queued_code_bytes = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   // predicted decoder state
   logic [8:0]  reg_cols;
   logic [7:0]  reg_rows;
   logic [7:0]  reg_burn;
   logic [23:0] held_bytes;
   int unsigned held_count;
   int unsigned pred_row;
   int unsigned pred_col;
   bit          decode_on;
   cell_type    cell_store [0:STORE_CELLS-1];

   // position tracking of the stimulus generator
   int unsigned plan_cols;
   int unsigned plan_rows;
   int unsigned plan_row;
   int unsigned plan_col;
   bit          plan_on;

   // sender burst and receiver stall pattern state
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_timer = 0;

   cell_stream_line_decoder_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_row       (rsp_cell_row),
      .rsp_cell_col       (rsp_cell_col),
      .rsp_cell_count     (rsp_cell_count),
      .rsp_mask_written   (rsp_mask_written),
      .rsp_color0_written (rsp_color0_written),
      .rsp_color1_written (rsp_color1_written),
      .rsp_mask_value     (rsp_mask_value),
      .rsp_color0_value   (rsp_color0_value),
      .rsp_color1_value   (rsp_color1_value),
      .rsp_status         (rsp_status),
      .rsp_row_done       (rsp_row_done),
      .rsp_frame_done     (rsp_frame_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // register values as the decoder uses them
   function automatic int unsigned clamp_cols(logic [8:0] v);
      if (v < 1) return 1;
      if (v > MAX_COLS) return MAX_COLS;
      return v;
   endfunction

   function automatic int unsigned clamp_rows(logic [7:0] v);
      if (v < 1) return 1;
      if (v > MAX_ROWS) return MAX_ROWS;
      return v;
   endfunction

   function automatic int unsigned code_length(logic [7:0] op);
      if ((op & LITERAL_FLAG) == 0) return 4;
      if ((op & ESCAPE_FLAG) == 0) return 1;
      if (op == OP_COLORS_ONLY || op == OP_MASK_ONLY) return 3;
      if (op == OP_COLOR0_ONLY || op == OP_COLOR1_ONLY) return 2;
      return 1;
   endfunction

   function automatic int unsigned store_index(int unsigned row, int unsigned col);
      if (row >= MAX_ROWS || col >= MAX_COLS) return 0;
      return row * MAX_COLS + col;
   endfunction

   function automatic string report_text(report_type r);
      return $sformatf("row %0d col %0d count %0d wr %b%b%b mask %h c0 %h c1 %h st %0d rd %b fd %b",
                       r.cell_row, r.cell_col, r.cell_count, r.mask_written,
                       r.color0_written, r.color1_written, r.mask_value, r.color0_value,
                       r.color1_value, r.status, r.row_done, r.frame_done);
   endfunction

   // register write: a write to index 0, 1 or 2 restarts decoding at the first burned row
   function automatic void apply_register(logic [1:0] idx, logic [8:0] value);
      int unsigned rows;
      int unsigned burn;
      case (idx)
         CSR_FRAME_COLS:    reg_cols = value;
         CSR_FRAME_ROWS:    reg_rows = value[7:0];
         CSR_LINES_TO_BURN: reg_burn = value[7:0];
         default: return;
      endcase
      rows = clamp_rows(reg_rows);
      burn = (reg_burn > rows) ? rows : reg_burn;
      held_bytes = '0;
      held_count = 0;
      pred_col = 0;
      pred_row = rows - burn;
      decode_on = (burn > 0);
   endfunction

   // one accepted byte: collect the code, then update the store and predict its report
   function automatic void decode_byte(logic [7:0] b);
      logic [7:0]  k0, k1, k2;
      int unsigned cols, avail, len, idx;
      bit          stop, advance;
      report_type  r;
      cell_type    c;
      if (!decode_on) return;
      if (held_count < 3) held_bytes[23 - 8 * held_count -: 8] = b;
      held_count++;
      if (held_count < code_length(held_bytes[23:16])) return;
      k0 = held_bytes[23:16];
      k1 = held_bytes[15:8];
      k2 = held_bytes[7:0];
      held_bytes = '0;
      held_count = 0;

      cols = clamp_cols(reg_cols);
      avail = (pred_col < cols) ? cols - pred_col : 0;
      r = '0;
      r.cell_row = pred_row[6:0];
      r.cell_col = pred_col[7:0];
      idx = store_index(pred_row, pred_col);
      stop = 1'b0;
      advance = 1'b1;

      if ((k0 & LITERAL_FLAG) == 0) begin
         r.mask_written = 1'b1;
         r.color0_written = 1'b1;
         r.color1_written = 1'b1;
         if ({k0, k1} != 16'h0000) begin
            // single cell with mask and both colors
            cell_store[idx] = {k0, k1, b, k2};
            r.cell_count = 9'd1;
            r.mask_value = {k0, k1};
            r.color0_value = b;
            r.color1_value = k2;
            pred_col++;
         end else begin
            // solid run, clipped at the row end
            len = int'(b) + 1;
            if (len > avail) begin
               len = avail;
               r.status = STATUS_OVERRUN;
               stop = 1'b1;
            end
            for (int unsigned i = 0; i < len; i++)
               cell_store[store_index(pred_row, pred_col + i)] = {16'h0000, k2, k2};
            r.cell_count = len[8:0];
            r.color0_value = k2;
            r.color1_value = k2;
            pred_col += len;
         end
      end else if ((k0 & ESCAPE_FLAG) == 0) begin
         // skip, clipped at the row end
         len = int'(k0 & SKIP_MASK) + 1;
         if (len > avail) begin
            len = avail;
            r.status = STATUS_OVERRUN;
            stop = 1'b1;
         end
         r.cell_count = len[8:0];
         pred_col += len;
      end else begin
         // escapes patch the current cell
         c = cell_store[idx];
         r.cell_count = 9'd1;
         case (k0)
            OP_COLORS_ONLY: begin
               c.color0 = k1;
               c.color1 = k2;
               r.color0_written = 1'b1;
               r.color1_written = 1'b1;
               r.color0_value = k1;
               r.color1_value = k2;
            end
            OP_COLOR0_ONLY: begin
               c.color0 = k1;
               r.color0_written = 1'b1;
               r.color0_value = k1;
            end
            OP_COLOR1_ONLY: begin
               c.color1 = k1;
               r.color1_written = 1'b1;
               r.color1_value = k1;
            end
            OP_MASK_ONLY: begin
               c.mask = {k1, k2};
               r.mask_written = 1'b1;
               r.mask_value = {k1, k2};
            end
            default: begin
               r.cell_count = 9'd0;
               r.status = STATUS_BAD_ESCAPE;
               stop = 1'b1;
               advance = 1'b0;
            end
         endcase
         if (advance) begin
            cell_store[idx] = c;
            pred_col++;
         end
      end

      // row and frame end
      if (advance && pred_col >= cols) begin
         r.row_done = 1'b1;
         pred_col = 0;
         pred_row++;
         if (pred_row >= clamp_rows(reg_rows)) begin
            r.frame_done = 1'b1;
            stop = 1'b1;
         end
      end
      if (stop) decode_on = 1'b0;
      expected_reports.push_back(r);
   endfunction

   function automatic void check_report(report_type got);
      report_type want;
      if (expected_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected report: %s", report_text(got));
         return;
      end
      want = expected_reports.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("report mismatch\n   expected %s\n   actual   %s",
                     report_text(want), report_text(got));
      end
   endfunction

   // monitor: register writes, byte transfers and report transfers
   always @(posedge clock) begin
      if (reset) begin
         reg_cols <= FRAME_COLS_RESET;
         reg_rows <= FRAME_ROWS_RESET;
         reg_burn <= LINES_TO_BURN_RESET;
         held_bytes <= '0;
         held_count <= 0;
         pred_row <= 0;
         pred_col <= 0;
         decode_on <= 1'b0;
         for (int i = 0; i < STORE_CELLS; i++) cell_store[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) decode_byte(req_stream_byte);
         if (rsp_valid && !rsp_stall)
            check_report({rsp_cell_row, rsp_cell_col, rsp_cell_count, rsp_mask_written,
                          rsp_color0_written, rsp_color1_written, rsp_mask_value,
                          rsp_color0_value, rsp_color1_value, rsp_status, rsp_row_done,
                          rsp_frame_done});
      end
   end

   // driver: bursts of bytes with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_stream_byte <= byte_queue.pop_front();
            if (burst_left <= 1) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left <= $urandom_range(50, 200);
                  gap_left <= 0;
               end else begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= $urandom_range(1, 6);
               end
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, switching between modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 300);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_register(input logic [1:0] idx, input logic [8:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // write all registers and set up the generator's position
   task automatic configure(input logic [8:0] cols, input logic [8:0] rows,
                            input logic [8:0] burn);
      int unsigned r, bn;
      write_register(CSR_FRAME_COLS, cols);
      write_register(CSR_FRAME_ROWS, rows);
      write_register(CSR_LINES_TO_BURN, burn);
      r = clamp_rows(rows[7:0]);
      bn = burn[7:0];
      if (bn > r) bn = r;
      plan_cols = clamp_cols(cols);
      plan_rows = r;
      plan_row = r - bn;
      plan_col = 0;
      plan_on = (bn > 0);
   endtask

   function automatic void add_code(int unsigned n, logic [7:0] b0, logic [7:0] b1,
                                    logic [7:0] b2, logic [7:0] b3);
      byte_queue.push_back(b0);
      if (n > 1) byte_queue.push_back(b1);
      if (n > 2) byte_queue.push_back(b2);
      if (n > 3) byte_queue.push_back(b3);
      queued_code_bytes += n;
   endfunction

   // wait for every byte and report, then let trailing store writes finish
   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   // well-formed codes that follow the frame, ended by a frame end, an error or a cap
   task automatic random_frame();
      int unsigned codes, n_codes, pick, avail, len, lim;
      logic [7:0]  b0, b1;
      bit          halt;
      n_codes = $urandom_range(4, 40);
      codes = 0;
      while (plan_on && codes < n_codes) begin
         avail = plan_cols - plan_col;
         pick = $urandom_range(0, 99);
         len = 1;
         halt = 1'b0;
         if (pick < 30) begin
            // literal cell with a nonzero mask
            b0 = $urandom_range(0, 127);
            b1 = $urandom_range(0, 255);
            if (b0 == 0 && b1 == 0) b1 = 8'h01;
            add_code(4, b0, b1, $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (pick < 42) begin
            // solid run
            lim = (avail < 12) ? avail : 12;
            if (avail < 256 && $urandom_range(0, 7) == 0) begin
               len = $urandom_range(avail + 1, 256);
               halt = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
               len = avail;
            end else begin
               len = $urandom_range(1, lim);
            end
            add_code(4, 8'h00, 8'h00, $urandom_range(0, 255), len - 1);
         end else if (pick < 57) begin
            // skip
            lim = (avail < 12) ? avail : 12;
            if (avail < 64 && $urandom_range(0, 7) == 0) begin
               len = $urandom_range(avail + 1, 64);
               halt = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
               len = (avail < 64) ? avail : 64;
            end else begin
               len = $urandom_range(1, lim);
            end
            add_code(1, LITERAL_FLAG | (len - 1), 8'h00, 8'h00, 8'h00);
         end else if (pick < 97) begin
            // escapes
            case ($urandom_range(0, 3))
               0: add_code(3, OP_COLORS_ONLY, $urandom_range(0, 255), $urandom_range(0, 255),
                           8'h00);
               1: add_code(2, OP_COLOR0_ONLY, $urandom_range(0, 255), 8'h00, 8'h00);
               2: add_code(2, OP_COLOR1_ONLY, $urandom_range(0, 255), 8'h00, 8'h00);
               default: add_code(3, OP_MASK_ONLY, $urandom_range(0, 255),
                                 $urandom_range(0, 255), 8'h00);
            endcase
         end else begin
            // unknown escape
            add_code(1, $urandom_range(8'hC0, OP_COLORS_ONLY - 1), 8'h00, 8'h00, 8'h00);
            len = 0;
            halt = 1'b1;
         end
         if (len > avail) len = avail;
         plan_col += len;
         if (!(halt && len == 0) && plan_col >= plan_cols) begin
            plan_col = 0;
            plan_row++;
            if (plan_row >= plan_rows) halt = 1'b1;
         end
         if (halt) plan_on = 1'b0;
         codes++;
      end
      // truncated code before the next restart, or ignored bytes after the end
      if (plan_on && $urandom_range(0, 1) == 0) begin
         byte_queue.push_back($urandom_range(0, 127));
         repeat ($urandom_range(0, 2)) byte_queue.push_back($urandom_range(0, 255));
      end else if (!plan_on) begin
         repeat ($urandom_range(0, 2)) byte_queue.push_back($urandom_range(0, 255));
      end
   endtask

   initial begin
      int unsigned directed_bytes, pick;
      logic [8:0]  cols_w, rows_w, burn_w;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // small frame: largest mask, smallest mask, every escape, short run and skip
      configure(9'd4, 9'd2, 9'd2);
      add_code(4, 8'h7F, 8'hFF, 8'h00, 8'hFF);
      add_code(4, 8'h00, 8'h01, 8'hAA, 8'h55);
      add_code(3, OP_COLORS_ONLY, 8'h12, 8'h34, 8'h00);
      add_code(2, OP_COLOR0_ONLY, 8'h56, 8'h00, 8'h00);
      add_code(2, OP_COLOR1_ONLY, 8'h78, 8'h00, 8'h00);
      add_code(3, OP_MASK_ONLY, 8'h80, 8'h01, 8'h00);
      add_code(4, 8'h00, 8'h00, 8'hC3, 8'h00);
      add_code(1, LITERAL_FLAG, 8'h00, 8'h00, 8'h00);
      drain();

      // saturated registers: widest row, longest skip, longest run overrunning the row
      configure(9'd511, 9'd0, 9'd255);
      add_code(1, LITERAL_FLAG | SKIP_MASK, 8'h00, 8'h00, 8'h00);
      add_code(4, 8'h00, 8'h00, 8'h11, 8'hFF);
      drain();

      // one-cell rows at the bottom of the tallest frame: unknown escape
      configure(9'd0, 9'd255, 9'd1);
      add_code(1, 8'hC0, 8'h00, 8'h00, 8'h00);
      drain();

      // skip overrun that ends a row short of the frame end
      configure(9'd1, 9'd128, 9'd2);
      add_code(1, LITERAL_FLAG | 8'h05, 8'h00, 8'h00, 8'h00);
      drain();

      // nothing to decode: bytes are ignored
      configure(9'd3, 9'd5, 9'd0);
      byte_queue.push_back(8'h40);
      drain();

      // random frames
      directed_bytes = queued_code_bytes;
      while (queued_code_bytes - directed_bytes < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: cols_w = 9'd0;
            1: cols_w = $urandom_range(257, 511);
            2: cols_w = MAX_COLS;
            3: cols_w = $urandom_range(1, MAX_COLS);
            default: cols_w = $urandom_range(1, 8);
         endcase
         rows_w = $urandom_range(0, 511);
         pick = $urandom_range(0, 11);
         case (pick)
            0: burn_w = $urandom_range(0, 1) * 256;
            1: burn_w = $urandom_range(129, 511);
            default: burn_w = $urandom_range(1, 3) + $urandom_range(0, 1) * 256;
         endcase
         configure(cols_w, rows_w, burn_w);
         if (!plan_on) repeat ($urandom_range(1, 3)) byte_queue.push_back($urandom_range(0, 255));
         random_frame();
         drain();
      end

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
